[hdl/ptla_pkg.sv]
// Shared types, constants and helpers for the peer table learn-and-age block.
`default_nettype none

package ptla_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Field widths
   localparam int MAGIC_W     = 32;
   localparam int KEY_W       = 32;
   localparam int PORT_W      = 16;
   localparam int TIME_W      = 32;
   localparam int TIMEOUT_W   = 16;
   localparam int SLOT_USED_W = 4;
   localparam int MASK_W      = 16;
   localparam int MASK_SRC_W  = (TABLE_DEPTH > MASK_W) ? TABLE_DEPTH : MASK_W;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_MAGIC  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_SECONDS = CSR_INDEX_W'(1);
   localparam logic [MAGIC_W-1:0]     MAGIC_RESET         = '0;
   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET       = TIMEOUT_W'(30);

   // Queues between the parts
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OUTCOME_IGNORED   = 2'd0,
      OUTCOME_REFRESHED = 2'd1,
      OUTCOME_INSERTED  = 2'd2,
      OUTCOME_DROPPED   = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MATCH,
      BACK_UPDATE,
      BACK_AGE
   } back_state_type;

   // Classified announcement handed from front to back
   typedef struct packed {
      logic              magic_ok;
      logic [KEY_W-1:0]  host_key;
      logic [PORT_W-1:0] listen_port;
      logic [TIME_W-1:0] now_seconds;
   } cmd_type;

   // One result transaction
   typedef struct packed {
      outcome_type            outcome;
      logic [SLOT_USED_W-1:0] slot_used;
      logic [MASK_W-1:0]      expired_mask;
      logic [MASK_W-1:0]      active_mask;
   } rsp_type;

   // Report the low slots of a per-slot vector, zero above the table
   function automatic logic [MASK_W-1:0] report_mask(input logic [TABLE_DEPTH-1:0] vec);
      logic [MASK_SRC_W-1:0] ext;
      ext = MASK_SRC_W'(vec);
      return ext[MASK_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hdl/ptla_front.sv]
// Front part: configuration of the magic word, classification and command queue.
`default_nettype none

module ptla_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_write_enable,
   input  wire  [ptla_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [ptla_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  wire                                  req_push,
   output logic                                 req_full,
   input  wire  [ptla_pkg::MAGIC_W-1:0]         req_magic_word,
   input  wire  [ptla_pkg::KEY_W-1:0]           req_host_key,
   input  wire  [ptla_pkg::PORT_W-1:0]          req_listen_port,
   input  wire  [ptla_pkg::TIME_W-1:0]          req_now_seconds,
   output logic                                 cmd_valid,
   output ptla_pkg::cmd_type                    cmd,
   input  wire                                  cmd_pop
);

   logic [ptla_pkg::MAGIC_W-1:0]     magic_ff;
   ptla_pkg::cmd_type                queue_ff [ptla_pkg::QUEUE_DEPTH];
   logic [ptla_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ptla_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ptla_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;
   ptla_pkg::cmd_type                push_cmd;

   // Hold the expected magic word
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= ptla_pkg::MAGIC_RESET;
      end else if (csr_write_enable && csr_index == ptla_pkg::CSR_EXPECTED_MAGIC) begin
         magic_ff <= csr_write_data[ptla_pkg::MAGIC_W-1:0];
      end
   end

   // Classify the incoming announcement
   always_comb begin
      push_cmd.magic_ok    = (req_magic_word == magic_ff);
      push_cmd.host_key    = req_host_key;
      push_cmd.listen_port = req_listen_port;
      push_cmd.now_seconds = req_now_seconds;
   end

   assign req_full  = (count_ff == ptla_pkg::QUEUE_CNT_W'(ptla_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ptla_pkg::QUEUE_PTR_W'(ptla_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ptla_pkg::QUEUE_PTR_W'(ptla_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[hdl/ptla_back.sv]
// Back part: peer table storage, match, learn and aging sequencer.
`default_nettype none

module ptla_back (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_write_enable,
   input  wire  [ptla_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [ptla_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  wire                                  cmd_valid,
   input  ptla_pkg::cmd_type                    cmd,
   output logic                                 cmd_pop,
   input  wire                                  rsp_full,
   output logic                                 rsp_push,
   output ptla_pkg::rsp_type                    rsp
);

   ptla_pkg::back_state_type             state_ff, state_in;
   logic [ptla_pkg::TIMEOUT_W-1:0]       timeout_ff;
   ptla_pkg::cmd_type                    cmd_ff, cmd_in;
   logic [ptla_pkg::TABLE_DEPTH-1:0]     hit_vec_ff, hit_vec_in;
   ptla_pkg::outcome_type                outcome_ff, outcome_in;
   logic [ptla_pkg::SLOT_W-1:0]          slot_ff, slot_in;
   logic [ptla_pkg::TABLE_DEPTH-1:0]     valid_ff, valid_in;
   logic [ptla_pkg::KEY_W-1:0]           key_ff  [ptla_pkg::TABLE_DEPTH];
   logic [ptla_pkg::KEY_W-1:0]           key_in  [ptla_pkg::TABLE_DEPTH];
   logic [ptla_pkg::PORT_W-1:0]          port_ff [ptla_pkg::TABLE_DEPTH];
   logic [ptla_pkg::PORT_W-1:0]          port_in [ptla_pkg::TABLE_DEPTH];
   logic [ptla_pkg::TIME_W-1:0]          seen_ff [ptla_pkg::TABLE_DEPTH];
   logic [ptla_pkg::TIME_W-1:0]          seen_in [ptla_pkg::TABLE_DEPTH];

   logic [ptla_pkg::TABLE_DEPTH-1:0]     match_vec;
   logic [ptla_pkg::TABLE_DEPTH-1:0]     expire_vec;
   logic                                 hit_found;
   logic [ptla_pkg::SLOT_W-1:0]          hit_idx;
   logic                                 free_found;
   logic [ptla_pkg::SLOT_W-1:0]          free_idx;
   logic [ptla_pkg::TIME_W-1:0]          timeout_ext;

   // Hold the timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ptla_pkg::TIMEOUT_RESET;
      end else if (csr_write_enable && csr_index == ptla_pkg::CSR_TIMEOUT_SECONDS) begin
         timeout_ff <= csr_write_data[ptla_pkg::TIMEOUT_W-1:0];
      end
   end

   assign timeout_ext = ptla_pkg::TIME_W'(timeout_ff);

   // Compare every slot against the latched key and port
   always_comb begin
      for (int i = 0; i < ptla_pkg::TABLE_DEPTH; i++) begin
         match_vec[i] = valid_ff[i] && key_ff[i] == cmd_ff.host_key &&
                        port_ff[i] == cmd_ff.listen_port;
      end
   end

   // Pick the lowest hit and the lowest free slot
   always_comb begin
      hit_found  = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ptla_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) begin
            hit_found = 1'b1;
            hit_idx   = ptla_pkg::SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = ptla_pkg::SLOT_W'(i);
         end
      end
   end

   // Age every slot; a bad magic word runs no sweep
   always_comb begin
      for (int i = 0; i < ptla_pkg::TABLE_DEPTH; i++) begin
         expire_vec[i] = cmd_ff.magic_ok && valid_ff[i] &&
                         ((cmd_ff.now_seconds - seen_ff[i]) > timeout_ext);
      end
   end

   // Sequence: take, match, update, age and report
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      hit_vec_in = hit_vec_ff;
      outcome_in = outcome_ff;
      slot_in    = slot_ff;
      valid_in   = valid_ff;
      key_in     = key_ff;
      port_in    = port_ff;
      seen_in    = seen_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;

      rsp.outcome      = outcome_ff;
      rsp.slot_used    = ptla_pkg::SLOT_USED_W'(slot_ff);
      rsp.expired_mask = ptla_pkg::report_mask(expire_vec);
      rsp.active_mask  = ptla_pkg::report_mask(valid_ff & ~expire_vec);

      case (state_ff)
         ptla_pkg::BACK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               cmd_in     = cmd;
               outcome_in = ptla_pkg::OUTCOME_IGNORED;
               slot_in    = '0;
               state_in   = cmd.magic_ok ? ptla_pkg::BACK_MATCH : ptla_pkg::BACK_AGE;
            end
         end
         ptla_pkg::BACK_MATCH: begin
            hit_vec_in = match_vec;
            state_in   = ptla_pkg::BACK_UPDATE;
         end
         ptla_pkg::BACK_UPDATE: begin
            if (hit_found) begin
               seen_in[hit_idx] = cmd_ff.now_seconds;
               outcome_in       = ptla_pkg::OUTCOME_REFRESHED;
               slot_in          = hit_idx;
            end else if (free_found) begin
               valid_in[free_idx] = 1'b1;
               key_in[free_idx]   = cmd_ff.host_key;
               port_in[free_idx]  = cmd_ff.listen_port;
               seen_in[free_idx]  = cmd_ff.now_seconds;
               outcome_in         = ptla_pkg::OUTCOME_INSERTED;
               slot_in            = free_idx;
            end else begin
               outcome_in = ptla_pkg::OUTCOME_DROPPED;
               slot_in    = '0;
            end
            state_in = ptla_pkg::BACK_AGE;
         end
         ptla_pkg::BACK_AGE: begin
            // Stall here until the result queue has room
            if (!rsp_full) begin
               rsp_push = 1'b1;
               valid_in = valid_ff & ~expire_vec;
               state_in = ptla_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = ptla_pkg::BACK_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptla_pkg::BACK_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Payload and table contents
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      hit_vec_ff <= hit_vec_in;
      outcome_ff <= outcome_in;
      slot_ff    <= slot_in;
      key_ff     <= key_in;
      port_ff    <= port_in;
      seen_ff    <= seen_in;
   end

endmodule

`default_nettype wire

[hdl/ptla_rsp_queue.sv]
// Result queue between the back part and the result ports.
`default_nettype none

module ptla_rsp_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ptla_pkg::rsp_type    push_data,
   output logic                 full,
   input  wire                  pop,
   output logic                 empty,
   output ptla_pkg::rsp_type    head
);

   ptla_pkg::rsp_type                queue_ff [ptla_pkg::QUEUE_DEPTH];
   logic [ptla_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ptla_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ptla_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full    = (count_ff == ptla_pkg::QUEUE_CNT_W'(ptla_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = queue_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ptla_pkg::QUEUE_PTR_W'(ptla_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ptla_pkg::QUEUE_PTR_W'(ptla_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the result transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hdl/peer_table_learn_and_age.sv]
// Top level of the peer table learn-and-age block.
//
//   channel   ports                                   handshake
//   request   req_magic_word/host_key/listen_port/    req_push, req_full
//             req_now_seconds
//   response  rsp_outcome/slot_used/expired_mask/     rsp_empty, rsp_pop
//             rsp_active_mask
//   config    csr_index, csr_write_data               csr_write_enable
//
// The back sequencer steps through take, match, update and age for an announcement with a
// good magic word and through take and age for one with a bad magic word; it takes the next
// announcement only once the last result is pushed, so it sets the rate. A request goes
// through the command queue, the sequencer steps and the result queue to the result ports.
// Two-entry queues on both sides let requests be taken while results wait to be popped;
// the sequencer holds in its aging step while the result queue is full.
// Synchronous reset clears the valid bits, queue pointers and counts and sequencer state at once.
`default_nettype none

module peer_table_learn_and_age (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_push,
   output logic                                 req_full,
   input  wire  [ptla_pkg::MAGIC_W-1:0]         req_magic_word,
   input  wire  [ptla_pkg::KEY_W-1:0]           req_host_key,
   input  wire  [ptla_pkg::PORT_W-1:0]          req_listen_port,
   input  wire  [ptla_pkg::TIME_W-1:0]          req_now_seconds,
   output logic                                 rsp_empty,
   input  wire                                  rsp_pop,
   output logic [1:0]                           rsp_outcome,
   output logic [ptla_pkg::SLOT_USED_W-1:0]     rsp_slot_used,
   output logic [ptla_pkg::MASK_W-1:0]          rsp_expired_mask,
   output logic [ptla_pkg::MASK_W-1:0]          rsp_active_mask,
   input  wire                                  csr_write_enable,
   input  wire  [ptla_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [ptla_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   logic              cmd_valid;
   ptla_pkg::cmd_type cmd;
   logic              cmd_pop;
   logic              rsp_full;
   logic              rsp_push;
   ptla_pkg::rsp_type rsp;
   ptla_pkg::rsp_type rsp_head;

   ptla_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_magic_word   (req_magic_word),
      .req_host_key     (req_host_key),
      .req_listen_port  (req_listen_port),
      .req_now_seconds  (req_now_seconds),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   ptla_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_full         (rsp_full),
      .rsp_push         (rsp_push),
      .rsp              (rsp)
   );

   ptla_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   // Drive the result ports from the queue head
   assign rsp_outcome      = rsp_head.outcome;
   assign rsp_slot_used    = rsp_head.slot_used;
   assign rsp_expired_mask = rsp_head.expired_mask;
   assign rsp_active_mask  = rsp_head.active_mask;

endmodule

`default_nettype wire

[hdl/ptla_checker.sv]
// Port-level checker for the peer table block and its bind statement.
`default_nettype none

module ptla_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_full,
   input wire                                  rsp_empty,
   input wire [1:0]                            rsp_outcome,
   input wire [ptla_pkg::SLOT_USED_W-1:0]      rsp_slot_used,
   input wire [ptla_pkg::MASK_W-1:0]           rsp_expired_mask,
   input wire [ptla_pkg::MASK_W-1:0]           rsp_active_mask
);

   // An ignored announcement touches nothing and names no slot
   ignored_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_outcome == ptla_pkg::OUTCOME_IGNORED) |->
      (rsp_slot_used == '0 && rsp_expired_mask == '0))
      else $error("ignored announcement reports a slot or expiry");

   // A dropped announcement found every slot in use before aging
   dropped_means_full: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_outcome == ptla_pkg::OUTCOME_DROPPED) |->
      (rsp_slot_used == '0 &&
       (rsp_active_mask | rsp_expired_mask) == ptla_pkg::report_mask('1)))
      else $error("dropped announcement while a slot was free");

   // A slot cannot expire and stay active in the same transaction
   expired_not_active: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_expired_mask & rsp_active_mask) == '0))
      else $error("slot both expired and active");

   // Reset leaves both queues empty
   reset_empties: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

bind peer_table_learn_and_age ptla_checker u_ptla_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_outcome      (rsp_outcome),
   .rsp_slot_used    (rsp_slot_used),
   .rsp_expired_mask (rsp_expired_mask),
   .rsp_active_mask  (rsp_active_mask)
);

`default_nettype wire
